// ===== hdl/psem_pkg.sv =====
// ----------------------------------------------------------------------------
// psem_pkg
// Shared types, widths and codes for the priority counting semaphore.
// ----------------------------------------------------------------------------
package psem_pkg;

    // Number of priority levels tracked in the wait set (8..64).
    localparam int PRIORITY_LEVELS = 64;

    localparam int PRIO_W     = 6;
    localparam int CNT_W      = 16;
    localparam int STATUS_W   = 3;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef logic [PRIORITY_LEVELS-1:0] t_mask;
    typedef logic [CNT_W-1:0]           t_count;
    typedef logic [PRIO_W-1:0]          t_prio;

    typedef enum logic [MODE_W-1:0] {
        MODE_WAIT    = 2'd0,
        MODE_TRY     = 2'd1,
        MODE_SIGNAL  = 2'd2,
        MODE_TIMEOUT = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED = 3'd0,
        ST_BLOCKED = 3'd1,
        ST_UNAVAIL = 3'd2,
        ST_REJECT  = 3'd3,
        ST_ACCEPT  = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_TOKENS     = 1'b0,
        CFG_INITIAL_TOKENS = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                  en;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        t_status status;
        logic    woken_valid;
        t_prio   woken_priority;
    } t_result;

endpackage

// ===== hdl/psem_if.sv =====
// ----------------------------------------------------------------------------
// psem_if
// Valid/ready channels of the semaphore: request, response, config write.
// ----------------------------------------------------------------------------
interface psem_req_if;
    import psem_pkg::*;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [PRIO_W-1:0] priority_req;

    modport source (output valid, mode, priority_req, input ready);
    modport sink   (input valid, mode, priority_req, output ready);
endinterface

interface psem_rsp_if;
    import psem_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                woken_valid;
    logic [PRIO_W-1:0]   woken_priority;

    modport source (output valid, status, woken_valid, woken_priority, input ready);
    modport sink   (input valid, status, woken_valid, woken_priority, output ready);
endinterface

interface psem_cfg_if;
    import psem_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/priority_counting_semaphore.sv =====
// ----------------------------------------------------------------------------
// priority_counting_semaphore
// Counting semaphore with a priority-ordered wait set and direct handoff.
// Pipeline: an accepted request passes through the input register, then the
//   result register, whose output drives the response.
// Throughput: 1 item per cycle while o_rsp.ready stays high; the count/mask
//   update and the 64-bit priority encoder are combinational.
// Reset: count 0, wait mask empty, max_tokens 1, initial_tokens 0.
// ----------------------------------------------------------------------------
module priority_counting_semaphore
    import psem_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    psem_cfg_if.sink   i_cfg,
    psem_req_if.sink   i_req,
    psem_rsp_if.source o_rsp
);

    // Input register stage
    logic  r_in_valid;
    t_mode r_mode;
    t_prio r_prio;

    // Result register stage
    logic    r_out_valid;
    t_result r_result;

    logic    step;      // item in input register moves to result register
    logic    out_free;  // result register can take an item
    logic    req_fire;
    t_cfg_wr cfg_wr;
    t_result core_result;

    // The user must write config only while idle; the block itself does not enforce it. Always ready
    assign i_cfg.ready = 1'b1;
    assign cfg_wr = '{en: i_cfg.valid, index: i_cfg.index, data: i_cfg.data};

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign step        = r_in_valid && out_free;
    // Take a new item whenever the input register is empty or empties this cycle
    assign i_req.ready = !r_in_valid || step;
    assign req_fire    = i_req.valid && i_req.ready;

    psem_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_wr),
        .i_step   (step),
        .i_mode   (r_mode),
        .i_prio   (r_prio),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (req_fire) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end

            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end

        // Payload, no reset
        if (req_fire) begin
            r_mode <= t_mode'(i_req.mode);
            r_prio <= i_req.priority_req;
        end
        if (step) begin
            r_result <= core_result;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_result.status;
    assign o_rsp.woken_valid    = r_result.woken_valid;
    assign o_rsp.woken_priority = r_result.woken_priority;

endmodule

// ===== hdl/psem_prio_enc.sv =====
// ----------------------------------------------------------------------------
// psem_prio_enc
// Highest-set-bit encoder over the wait mask.
// ----------------------------------------------------------------------------
module psem_prio_enc
    import psem_pkg::*;
(
    input  t_mask i_mask,
    output logic  o_found,
    output t_prio o_index
);

    always_comb begin
        o_index = '0;
        for (int i = 0; i < PRIORITY_LEVELS; i++) begin
            if (i_mask[i]) begin
                o_index = PRIO_W'(i);
            end
        end
    end

    assign o_found = |i_mask;

endmodule

// ===== hdl/psem_core.sv =====
// ----------------------------------------------------------------------------
// psem_core
// Token count, wait mask and config registers; one request per step.
// ----------------------------------------------------------------------------
module psem_core
    import psem_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg,
    input  logic    i_step,
    input  t_mode   i_mode,
    input  t_prio   i_prio,
    output t_result o_result
);

    t_count r_max, n_max;
    t_count r_init, n_init;
    t_count r_cnt, n_cnt;
    t_mask  r_mask, n_mask;

    t_count eff_max;
    t_mask  req_bit;
    logic   wake_found;
    t_prio  wake_idx;

    // Zero limit behaves as one
    assign eff_max = (r_max == '0) ? t_count'(1) : r_max;
    // Shift past the mask width drops out-of-range priorities
    assign req_bit = t_mask'(1) << i_prio;

    psem_prio_enc u_enc (
        .i_mask  (r_mask),
        .o_found (wake_found),
        .o_index (wake_idx)
    );

    always_comb begin
        n_max    = r_max;
        n_init   = r_init;
        n_cnt    = r_cnt;
        n_mask   = r_mask;
        o_result = '{status: ST_GRANTED, woken_valid: 1'b0, woken_priority: '0};

        if (i_cfg.en) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_MAX_TOKENS: begin
                    n_max = i_cfg.data;
                end
                CFG_INITIAL_TOKENS: begin
                    n_init = i_cfg.data;
                    n_cnt  = (i_cfg.data > eff_max) ? eff_max : i_cfg.data;
                    n_mask = '0;
                end
                default: begin
                    n_max = r_max;
                end
            endcase
        end

        // Request state only moves when an item steps through
        if (i_step) begin
            case (i_mode)
                MODE_WAIT: begin
                    if (r_cnt != '0) begin
                        n_cnt = r_cnt - t_count'(1);
                    end else if (req_bit != '0) begin
                        n_mask          = r_mask | req_bit;
                        o_result.status = ST_BLOCKED;
                    end else begin
                        o_result.status = ST_UNAVAIL;
                    end
                end
                MODE_TRY: begin
                    if (r_cnt != '0) begin
                        n_cnt = r_cnt - t_count'(1);
                    end else begin
                        o_result.status = ST_UNAVAIL;
                    end
                end
                MODE_SIGNAL: begin
                    if (r_cnt < eff_max) begin
                        // Direct handoff to the top waiter, count unchanged
                        if (wake_found) begin
                            n_mask                  = r_mask & ~(t_mask'(1) << wake_idx);
                            o_result.woken_valid    = 1'b1;
                            o_result.woken_priority = wake_idx;
                        end else begin
                            n_cnt = r_cnt + t_count'(1);
                        end
                        o_result.status = ST_ACCEPT;
                    end else begin
                        o_result.status = ST_REJECT;
                    end
                end
                default: begin
                    // Timeout: still waiting -> removed; not waiting (woken or never waited) -> granted
                    if (req_bit == '0) begin
                        o_result.status = ST_UNAVAIL;
                    end else if ((r_mask & req_bit) != '0) begin
                        n_mask          = r_mask & ~req_bit;
                        o_result.status = ST_UNAVAIL;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max  <= t_count'(1);
            r_init <= '0;
            r_cnt  <= '0;
            r_mask <= '0;
        end else begin
            r_max  <= n_max;
            r_init <= n_init;
            r_cnt  <= n_cnt;
            r_mask <= n_mask;
        end
    end

endmodule

// ===== hdl/psem_checker.sv =====
// ----------------------------------------------------------------------------
// psem_checker
// Port-level checks on the semaphore response channel.
// ----------------------------------------------------------------------------
module psem_checker
    import psem_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                i_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic                i_woken_valid,
    input logic [PRIO_W-1:0]   i_woken_priority
);

    // A wakeup only comes with an accepted signal
    a_wake_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_woken_valid) |-> (i_status == ST_ACCEPT))
        else $error("wakeup without accepted signal");

    // No wakeup means a zero priority field
    a_wake_prio_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_woken_valid) |-> (i_woken_priority == '0))
        else $error("woken priority set without wakeup");

    // Status stays within the defined codes
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_status == ST_GRANTED || i_status == ST_BLOCKED ||
                     i_status == ST_UNAVAIL || i_status == ST_REJECT ||
                     i_status == ST_ACCEPT))
        else $error("undefined status code");

    // Stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_status) &&
                                   $stable(i_woken_valid) && $stable(i_woken_priority)))
        else $error("stalled response changed");

endmodule

bind priority_counting_semaphore psem_checker u_psem_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_rsp.valid),
    .i_ready          (o_rsp.ready),
    .i_status         (o_rsp.status),
    .i_woken_valid    (o_rsp.woken_valid),
    .i_woken_priority (o_rsp.woken_priority)
);

// ===== verif/priority_counting_semaphore_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_counting_semaphore_tb
// Self-checking bench for the priority counting semaphore. A directed table
// walks the corner cases (repeat waits, timeouts racing a wakeup, reinit,
// clamped and lowered limits), then random phases under several limit and
// count settings exercise the token and wait-set handling. Every response is
// checked field by field against the row's hand-written response or an
// in-bench model of the token count and the priority wait set.
// ----------------------------------------------------------------------------
module priority_counting_semaphore_tb;
    import psem_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 100;
    localparam int DRAIN_TAIL  = 8;     // well past the response pipeline

    logic i_clk;
    logic i_rst_n;

    psem_req_if req_ch ();
    psem_rsp_if rsp_ch ();
    psem_cfg_if cfg_ch ();

    priority_counting_semaphore dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // ------------------------------------------------------------------
    // Bench model of the semaphore: limit, reload value, count, waiters
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] sem_max;
    logic [CFG_DATA_W-1:0] sem_init;
    t_count                sem_count;
    t_mask                 sem_waiters;

    t_result pending_results[$];    // responses owed by the block, oldest first

    int errors;
    int cycle_count;
    int idle_pct;                   // chance of a stall burst, both sides
    int n_items, n_cfg, n_woken, n_blocked, n_rejected, n_timeouts;

    // limit of zero behaves as one
    function automatic t_count sem_limit();
        return (sem_max == '0) ? t_count'(1) : t_count'(sem_max);
    endfunction

    // register write: max only moves the limit, initial reloads and empties
    function automatic void sem_write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        if (idx == CFG_MAX_TOKENS) begin
            sem_max = val;
        end else begin
            sem_init    = val;
            sem_count   = (t_count'(val) > sem_limit()) ? sem_limit() : t_count'(val);
            sem_waiters = '0;
        end
    endfunction

    // one request: update count / wait set, return the response it earns
    function automatic t_result sem_apply(t_mode m, t_prio p);
        t_result r;
        bit      in_range;
        int      top;
        r.status         = ST_GRANTED;
        r.woken_valid    = 1'b0;
        r.woken_priority = '0;
        in_range         = (int'(p) < PRIORITY_LEVELS);
        case (m)
            MODE_WAIT: begin
                if (sem_count != '0) begin
                    sem_count = sem_count - 1'b1;
                end else if (in_range) begin
                    sem_waiters[p] = 1'b1;
                    r.status       = ST_BLOCKED;
                end else begin
                    r.status = ST_UNAVAIL;
                end
            end
            MODE_TRY: begin
                if (sem_count != '0) sem_count = sem_count - 1'b1;
                else r.status = ST_UNAVAIL;
            end
            MODE_SIGNAL: begin
                if (sem_count < sem_limit()) begin
                    if (sem_waiters != '0) begin
                        // direct handoff to the highest waiting priority
                        top = 0;
                        for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
                            if (sem_waiters[i] && top == 0 && i != 0) top = i;
                        end
                        sem_waiters[top] = 1'b0;
                        r.woken_valid    = 1'b1;
                        r.woken_priority = t_prio'(top);
                    end else begin
                        sem_count = sem_count + 1'b1;
                    end
                    r.status = ST_ACCEPT;
                end else begin
                    r.status = ST_REJECT;
                end
            end
            default: begin
                if (!in_range) begin
                    r.status = ST_UNAVAIL;
                end else if (sem_waiters[p]) begin
                    sem_waiters[p] = 1'b0;
                    r.status       = ST_UNAVAIL;
                end
                // not waiting (already handed a token, or never waited) -> granted
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct {
        bit                    is_cfg;
        t_cfg_idx              reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        t_mode                 mode;
        t_prio                 prio;
        bit                    typed;   // want holds a hand-written response
        t_result               want;
    } t_stim_row;

    t_stim_row directed_rows[$];

    function automatic t_stim_row row_req(t_mode m, int p);
        t_stim_row s;
        s.is_cfg  = 1'b0;
        s.reg_idx = CFG_MAX_TOKENS;
        s.reg_val = '0;
        s.mode    = m;
        s.prio    = t_prio'(p);
        s.typed   = 1'b0;
        s.want    = '0;
        return s;
    endfunction

    function automatic t_stim_row row_chk(t_mode m, int p, t_status st, bit wv, int wp);
        t_stim_row s;
        s                     = row_req(m, p);
        s.typed               = 1'b1;
        s.want.status         = st;
        s.want.woken_valid    = wv;
        s.want.woken_priority = t_prio'(wp);
        return s;
    endfunction

    function automatic t_stim_row row_reg(t_cfg_idx idx, int val);
        t_stim_row s;
        s         = row_req(MODE_WAIT, 0);
        s.is_cfg  = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val[CFG_DATA_W-1:0];
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d responses outstanding",
                     $time, cycle_count, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Response side: random ready stalls, checked at the rising edge
    // ------------------------------------------------------------------
    int stall_left;

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            rsp_ch.ready  <= 1'b0;
        end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            stall_left    <= $urandom_range(0, 4);    // random burst length, incl. this one
            rsp_ch.ready  <= 1'b0;
        end else begin
            rsp_ch.ready  <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : rsp_check
        t_result got;
        t_result exp_r;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.status         = t_status'(rsp_ch.status);
            got.woken_valid    = rsp_ch.woken_valid;
            got.woken_priority = rsp_ch.woken_priority;
            if (pending_results.size() == 0) begin
                $display("%0t: response with nothing outstanding: status=%0d wv=%0b wp=%0d",
                         $time, got.status, got.woken_valid, got.woken_priority);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (got.status !== exp_r.status) begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, exp_r.status, rsp_ch.status);
                    errors++;
                end
                if (got.woken_valid !== exp_r.woken_valid) begin
                    $display("%0t: woken_valid mismatch: expected %0b, got %0b",
                             $time, exp_r.woken_valid, rsp_ch.woken_valid);
                    errors++;
                end
                if (got.woken_priority !== exp_r.woken_priority) begin
                    $display("%0t: woken_priority mismatch: expected %0d, got %0d",
                             $time, exp_r.woken_priority, rsp_ch.woken_priority);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request / config drivers. Each task is entered just after a falling
    // edge, drives there, and returns just after a later falling edge
    // without having driven in that step, so no signal sees two updates
    // in one time step.
    // ------------------------------------------------------------------
    task automatic send_req(t_mode m, t_prio p, bit typed, t_result want);
        t_result r;
        cfg_ch.valid <= 1'b0;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= m;
        req_ch.priority_req <= p;
        do @(posedge i_clk); while (!req_ch.ready);
        r = sem_apply(m, p);
        pending_results.push_back(typed ? want : r);
        n_items++;
        if (r.woken_valid) n_woken++;
        if (r.status == ST_BLOCKED) n_blocked++;
        if (r.status == ST_REJECT) n_rejected++;
        if (m == MODE_TIMEOUT) n_timeouts++;
        @(negedge i_clk);
    endtask

    // hold requests and writes back until every owed response has come out
    task automatic drain_all();
        req_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    // registers only change with the block idle
    task automatic cfg_write(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        drain_all();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sem_write_reg(idx, val);
        n_cfg++;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        t_mode                 m;
        t_prio                 p;
        t_result               none;
        int                    pick, start;
        logic [CFG_DATA_W-1:0] lim_a, lim_b, reload;

        // every input known from time zero; reset held low at the start
        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.mode         = MODE_WAIT;
        req_ch.priority_req = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_MAX_TOKENS;
        cfg_ch.data         = '0;
        rsp_ch.ready        = 1'b0;
        stall_left          = 0;
        cycle_count         = 0;
        errors              = 0;
        idle_pct            = 20;
        n_items = 0; n_cfg = 0; n_woken = 0; n_blocked = 0; n_rejected = 0;
        n_timeouts = 0;
        none = '0;

        // reset state: limit 1, count 0, nobody waiting
        sem_max     = 16'd1;
        sem_init    = '0;
        sem_count   = '0;
        sem_waiters = '0;

        // directed: starts from reset, limit 1, count 0
        directed_rows.push_back(row_chk(MODE_TRY,     0,  ST_UNAVAIL, 0, 0));
        directed_rows.push_back(row_chk(MODE_WAIT,    63, ST_BLOCKED, 0, 0));
        // waiting again at the same level keeps one entry
        directed_rows.push_back(row_chk(MODE_WAIT,    63, ST_BLOCKED, 0, 0));
        directed_rows.push_back(row_chk(MODE_WAIT,    0,  ST_BLOCKED, 0, 0));
        // handoff goes highest first, count untouched
        directed_rows.push_back(row_chk(MODE_SIGNAL,  5,  ST_ACCEPT,  1, 63));
        directed_rows.push_back(row_chk(MODE_SIGNAL,  0,  ST_ACCEPT,  1, 0));
        // timeout after the wakeup already landed
        directed_rows.push_back(row_chk(MODE_TIMEOUT, 63, ST_GRANTED, 0, 0));
        directed_rows.push_back(row_chk(MODE_WAIT,    31, ST_BLOCKED, 0, 0));
        directed_rows.push_back(row_chk(MODE_TIMEOUT, 31, ST_UNAVAIL, 0, 0));
        // timeout for a level that never waited
        directed_rows.push_back(row_chk(MODE_TIMEOUT, 17, ST_GRANTED, 0, 0));
        directed_rows.push_back(row_chk(MODE_SIGNAL,  42, ST_ACCEPT,  0, 0));
        directed_rows.push_back(row_chk(MODE_SIGNAL,  0,  ST_REJECT,  0, 0));
        directed_rows.push_back(row_chk(MODE_WAIT,    42, ST_GRANTED, 0, 0));
        directed_rows.push_back(row_req(MODE_WAIT,    12));
        directed_rows.push_back(row_req(MODE_WAIT,    50));
        // zero limit acts as one; reload is clamped and empties the wait set
        directed_rows.push_back(row_reg(CFG_MAX_TOKENS, 0));
        directed_rows.push_back(row_reg(CFG_INITIAL_TOKENS, 65535));
        directed_rows.push_back(row_chk(MODE_SIGNAL,  63, ST_REJECT,  0, 0));
        directed_rows.push_back(row_chk(MODE_TIMEOUT, 50, ST_GRANTED, 0, 0));
        directed_rows.push_back(row_chk(MODE_TRY,     63, ST_GRANTED, 0, 0));
        // full-scale count
        directed_rows.push_back(row_reg(CFG_MAX_TOKENS, 65535));
        directed_rows.push_back(row_reg(CFG_INITIAL_TOKENS, 65535));
        directed_rows.push_back(row_chk(MODE_SIGNAL,  21, ST_REJECT,  0, 0));
        directed_rows.push_back(row_chk(MODE_WAIT,    1,  ST_GRANTED, 0, 0));
        directed_rows.push_back(row_chk(MODE_SIGNAL,  0,  ST_ACCEPT,  0, 0));
        // lowering the limit under the count: signals bounce until it drops
        directed_rows.push_back(row_reg(CFG_MAX_TOKENS, 2));
        directed_rows.push_back(row_chk(MODE_SIGNAL,  0,  ST_REJECT,  0, 0));
        directed_rows.push_back(row_req(MODE_TRY,     7));
        directed_rows.push_back(row_req(MODE_SIGNAL,  7));
        directed_rows.push_back(row_reg(CFG_INITIAL_TOKENS, 0));
        directed_rows.push_back(row_req(MODE_WAIT,    9));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg)
                cfg_write(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            else
                send_req(directed_rows[i].mode, directed_rows[i].prio,
                         directed_rows[i].typed, directed_rows[i].want);
        end

        // random phases, each under its own limit / reload setting
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0:       begin lim_a = 16'd4;     reload = 16'd0;     lim_b = lim_a; end
                1:       begin lim_a = 16'd1;     reload = 16'd0;     lim_b = lim_a; end
                2:       begin lim_a = 16'hFFFF;  reload = 16'hFFFA;  lim_b = lim_a; end
                3:       begin lim_a = 16'd0;     reload = 16'd3;     lim_b = lim_a; end
                4: begin
                    lim_a  = 16'($urandom_range(1, 16));
                    reload = 16'($urandom_range(0, 16));
                    lim_b  = lim_a;
                end
                5: begin
                    // count left above a freshly lowered limit
                    lim_a  = 16'hFFFF;
                    reload = 16'($urandom_range(4, 12));
                    lim_b  = 16'($urandom_range(1, 3));
                end
                6: begin
                    lim_a  = 16'($urandom);
                    reload = 16'($urandom);
                    lim_b  = lim_a;
                end
                default: begin lim_a = 16'd8;     reload = 16'd0;     lim_b = lim_a; end
            endcase
            // no stalls in every third phase and in the last one
            idle_pct = (ph % 3 == 2 || ph == N_PHASES - 1) ? 0 : 25;
            cfg_write(CFG_MAX_TOKENS, lim_a);
            cfg_write(CFG_INITIAL_TOKENS, reload);
            if (lim_b != lim_a) cfg_write(CFG_MAX_TOKENS, lim_b);

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // occasionally let the pipeline run dry mid-phase
                if ($urandom_range(0, 49) == 0) drain_all();
                pick = $urandom_range(0, 99);
                if (pick < 35)      m = MODE_WAIT;
                else if (pick < 45) m = MODE_TRY;
                else if (pick < 78) m = MODE_SIGNAL;
                else                m = MODE_TIMEOUT;
                p = t_prio'($urandom_range(0, 63));
                // timeouts mostly target a level that is really waiting
                if (m == MODE_TIMEOUT && sem_waiters != '0 && $urandom_range(0, 99) < 60) begin
                    start = $urandom_range(0, 63);
                    for (int j = 0; j < 64; j++) begin
                        if (sem_waiters[(start + j) % 64]) begin
                            p = t_prio'((start + j) % 64);
                            break;
                        end
                    end
                end
                send_req(m, p, 1'b0, none);
            end
        end

        drain_all();
        repeat (DRAIN_TAIL) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d responses never arrived", $time, pending_results.size());
            errors++;
        end

        $display("Ran %0d requests over %0d register writes: %0d blocked, %0d handoffs,",
                 n_items, n_cfg, n_blocked, n_woken);
        $display("  %0d rejected signals, %0d timeouts, %0d mismatches",
                 n_rejected, n_timeouts, errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/psem_pkg.sv
hdl/psem_if.sv
hdl/psem_prio_enc.sv
hdl/psem_core.sv
hdl/priority_counting_semaphore.sv
hdl/psem_checker.sv
verif/priority_counting_semaphore_tb.sv
